// ----- sv/sqvg_pkg.sv -----
package sqvg_pkg;

  // Field and datapath widths
  localparam int TSIZE_W   = 13;  // texture size register
  localparam int EDGE_W    = 13;  // texel edge, src + size
  localparam int RECIP_W   = 30;  // floor(2^29 / size)
  localparam int Q_W       = 17;  // unsaturated tex quotient
  localparam int TEX_W     = 18;  // tex coordinate, Q.16 up to 2.0
  localparam int STEP_W    = 5;   // reciprocal divider step counter
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  localparam logic [RECIP_W-1:0] RECIP_ONE     = 30'h2000_0000;  // 2^29 / 1
  localparam logic [STEP_W-1:0]  DIV_LAST_STEP = 5'd29;
  localparam logic [TEX_W-1:0]   TEX_MAX       = 18'd131072;
  localparam logic [1:0]         CORNER_LAST   = 2'd3;

  typedef struct packed {
    logic signed [15:0] coef_xx;
    logic signed [15:0] coef_xy;
    logic signed [15:0] coef_yx;
    logic signed [15:0] coef_yy;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [31:0]        color_rgba;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [TEX_W-1:0]   tex_s;
    logic [TEX_W-1:0]   tex_t;
    logic [31:0]        vertex_color;
    logic [1:0]         corner;
    logic               last_vertex;
  } out_item_t;

  // Queued sprite, edges already formed
  typedef struct packed {
    logic signed [15:0] coef_xx;
    logic signed [15:0] coef_xy;
    logic signed [15:0] coef_yx;
    logic signed [15:0] coef_yy;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [EDGE_W-1:0]  s_near;
    logic [EDGE_W-1:0]  s_far;
    logic [EDGE_W-1:0]  t_near;
    logic [EDGE_W-1:0]  t_far;
    logic [31:0]        color;
  } sq_entry_t;

  // Texture scale state shared by front and back
  typedef struct packed {
    logic               busy;
    logic [TSIZE_W-1:0] tex_w;    // effective, never zero
    logic [TSIZE_W-1:0] tex_h;
    logic [RECIP_W-1:0] recip_w;
    logic [RECIP_W-1:0] recip_h;
  } tex_scale_t;

endpackage

// ----- sv/sqvg_recip.sv -----
module sqvg_recip
  import sqvg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TSIZE_W-1:0]   cfg_data,
  output tex_scale_t           scale
);

  logic [TSIZE_W-1:0]   tex_w_r, tex_h_r;
  logic [RECIP_W-1:0]   recip_w_r, recip_h_r;
  logic                 busy_r;
  logic [CFG_IDX_W-1:0] tgt_r;
  logic [TSIZE_W-1:0]   div_r;
  logic [TSIZE_W-1:0]   rem_r;
  logic [RECIP_W-1:0]   quo_r;
  logic [STEP_W-1:0]    step_r;

  logic                 wr;
  logic [TSIZE_W-1:0]   d_new;
  logic [TSIZE_W:0]     rem_sh;
  logic                 ge;
  logic [TSIZE_W-1:0]   rem_nxt;
  logic [RECIP_W-1:0]   quo_nxt;

  assign cfg_ready = !busy_r;
  assign wr        = cfg_valid && cfg_ready;
  // a size of zero behaves as one
  assign d_new     = (cfg_data == '0) ? TSIZE_W'(1) : cfg_data;

  // Restoring divide of 2^29 by the size, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, (step_r == DIV_LAST_STEP)};
    ge      = rem_sh >= {1'b0, div_r};
    rem_nxt = ge ? TSIZE_W'(rem_sh - {1'b0, div_r}) : rem_sh[TSIZE_W-1:0];
    quo_nxt = {quo_r[RECIP_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      tex_w_r   <= TSIZE_W'(1);
      tex_h_r   <= TSIZE_W'(1);
      recip_w_r <= RECIP_ONE;
      recip_h_r <= RECIP_ONE;
    end else if (wr) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_w_r <= d_new;
        REG_TEX_HEIGHT: tex_h_r <= d_new;
        default: ;
      endcase
      busy_r <= 1'b1;
      tgt_r  <= cfg_index;
      div_r  <= d_new;
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= DIV_LAST_STEP;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r - STEP_W'(1);
      if (step_r == '0) begin
        busy_r <= 1'b0;
        case (tgt_r)
          REG_TEX_WIDTH:  recip_w_r <= quo_nxt;
          REG_TEX_HEIGHT: recip_h_r <= quo_nxt;
          default: ;
        endcase
      end
    end
  end

  // a write in flight also holds off new items
  assign scale.busy    = busy_r || cfg_valid;
  assign scale.tex_w   = tex_w_r;
  assign scale.tex_h   = tex_h_r;
  assign scale.recip_w = recip_w_r;
  assign scale.recip_h = recip_h_r;

endmodule

// ----- sv/sqvg_front.sv -----
module sqvg_front
  import sqvg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  input  logic      hold,
  output logic      head_valid,
  output sq_entry_t head,
  input  logic      pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sq_entry_t          queue_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  logic      push;
  logic      full;
  sq_entry_t entry;

  assign full     = count_r == CNT_W'(DEPTH);
  assign in_stall = full || hold;
  assign push     = in_valid && !in_stall;

  // Classify: form the near and far texel edges of the sprite
  always_comb begin
    entry.coef_xx     = in_item.coef_xx;
    entry.coef_xy     = in_item.coef_xy;
    entry.coef_yx     = in_item.coef_yx;
    entry.coef_yy     = in_item.coef_yy;
    entry.shift_x     = in_item.shift_x;
    entry.shift_y     = in_item.shift_y;
    entry.rect_width  = in_item.rect_width;
    entry.rect_height = in_item.rect_height;
    entry.s_near      = {1'b0, in_item.src_x};
    entry.s_far       = {1'b0, in_item.src_x} + {1'b0, in_item.rect_width};
    entry.t_near      = {1'b0, in_item.src_y};
    entry.t_far       = {1'b0, in_item.src_y} + {1'b0, in_item.rect_height};
    entry.color       = in_item.color_rgba;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_valid = count_r != '0;
  assign head       = queue_r[rd_ptr_r];

endmodule

// ----- sv/sqvg_back.sv -----
module sqvg_back
  import sqvg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  sq_entry_t  head,
  output logic       pop,
  input  tex_scale_t scale,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  // Stage 1: products
  typedef struct packed {
    logic signed [28:0]       mxx;
    logic signed [28:0]       mxy;
    logic signed [28:0]       myx;
    logic signed [28:0]       myy;
    logic signed [31:0]       shift_x;
    logic signed [31:0]       shift_y;
    logic [EDGE_W+RECIP_W-1:0] prod_s;
    logic [EDGE_W+RECIP_W-1:0] prod_t;
    logic [EDGE_W-1:0]        es;
    logic [EDGE_W-1:0]        et;
    logic                     sat_s;
    logic                     sat_t;
    logic [31:0]              color;
    logic [1:0]               corner;
  } s1_t;

  // Stage 2: sums and quotient check products
  typedef struct packed {
    logic signed [29:0]   sum_x;
    logic signed [29:0]   sum_y;
    logic signed [31:0]   shift_x;
    logic signed [31:0]   shift_y;
    logic [Q_W-1:0]       q0_s;
    logic [Q_W-1:0]       q0_t;
    logic [Q_W+TSIZE_W-1:0] qd_s;
    logic [Q_W+TSIZE_W-1:0] qd_t;
    logic [EDGE_W-1:0]    es;
    logic [EDGE_W-1:0]    et;
    logic                 sat_s;
    logic                 sat_t;
    logic [31:0]          color;
    logic [1:0]           corner;
  } s2_t;

  logic [1:0] corner_r;
  logic       v1_r, v2_r, out_valid_r;
  s1_t        s1_r, s1_nxt;
  s2_t        s2_r, s2_nxt;
  out_item_t  out_r, out_nxt;

  logic              adv, issue, right, bottom;
  logic [11:0]       px, py;
  logic [EDGE_W-1:0] es, et;

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      return v[31:0];
    end else if (v[34]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  function automatic logic [TEX_W-1:0] tex_fix(
    input logic             sat,
    input logic [Q_W-1:0]   q0,
    input logic [Q_W+TSIZE_W-1:0] qd,
    input logic [EDGE_W-1:0] e,
    input logic [TSIZE_W-1:0] d
  );
    logic [Q_W+TSIZE_W-1:0] rem;
    logic                   corr;
    rem  = {1'b0, e, 16'h0000} - qd;
    corr = rem >= {{Q_W{1'b0}}, d};
    if (sat) begin
      return TEX_MAX;
    end else begin
      return {1'b0, q0 + Q_W'(corr)};
    end
  endfunction

  // Whole pipeline moves unless the output register is held
  assign adv   = !out_valid_r || !out_stall;
  assign issue = head_valid && adv;
  assign pop   = issue && (corner_r == CORNER_LAST);

  // Issue: pick the corner of the head sprite
  always_comb begin
    right  = corner_r[0] ^ corner_r[1];
    bottom = corner_r[1];
    px     = right  ? head.rect_width  : '0;
    py     = bottom ? head.rect_height : '0;
    es     = right  ? head.s_far : head.s_near;
    et     = bottom ? head.t_far : head.t_near;

    s1_nxt.mxx     = head.coef_xx * $signed({1'b0, px});
    s1_nxt.mxy     = head.coef_xy * $signed({1'b0, py});
    s1_nxt.myx     = head.coef_yx * $signed({1'b0, px});
    s1_nxt.myy     = head.coef_yy * $signed({1'b0, py});
    s1_nxt.shift_x = head.shift_x;
    s1_nxt.shift_y = head.shift_y;
    // estimate edge * 2^16 / size as (edge * floor(2^29 / size)) >> 13
    s1_nxt.prod_s  = es * scale.recip_w;
    s1_nxt.prod_t  = et * scale.recip_h;
    s1_nxt.es      = es;
    s1_nxt.et      = et;
    // quotient reaches 2.0 exactly when edge >= 2 * size
    s1_nxt.sat_s   = {1'b0, es} >= {scale.tex_w, 1'b0};
    s1_nxt.sat_t   = {1'b0, et} >= {scale.tex_h, 1'b0};
    s1_nxt.color   = head.color;
    s1_nxt.corner  = corner_r;
  end

  // Stage 2: matrix sums, estimate times size
  always_comb begin
    s2_nxt.sum_x   = s1_r.mxx + s1_r.mxy;
    s2_nxt.sum_y   = s1_r.myx + s1_r.myy;
    s2_nxt.shift_x = s1_r.shift_x;
    s2_nxt.shift_y = s1_r.shift_y;
    s2_nxt.q0_s    = s1_r.prod_s[Q_W+12:13];
    s2_nxt.q0_t    = s1_r.prod_t[Q_W+12:13];
    s2_nxt.qd_s    = s1_r.prod_s[Q_W+12:13] * scale.tex_w;
    s2_nxt.qd_t    = s1_r.prod_t[Q_W+12:13] * scale.tex_h;
    s2_nxt.es      = s1_r.es;
    s2_nxt.et      = s1_r.et;
    s2_nxt.sat_s   = s1_r.sat_s;
    s2_nxt.sat_t   = s1_r.sat_t;
    s2_nxt.color   = s1_r.color;
    s2_nxt.corner  = s1_r.corner;
  end

  // Stage 3: Q.12 to Q16.16, translate, saturate; quotient correction
  always_comb begin
    out_nxt.pos_x        = sat32($signed({s2_r.sum_x, 4'h0}) + s2_r.shift_x);
    out_nxt.pos_y        = sat32($signed({s2_r.sum_y, 4'h0}) + s2_r.shift_y);
    out_nxt.tex_s        = tex_fix(s2_r.sat_s, s2_r.q0_s, s2_r.qd_s, s2_r.es, scale.tex_w);
    out_nxt.tex_t        = tex_fix(s2_r.sat_t, s2_r.q0_t, s2_r.qd_t, s2_r.et, scale.tex_h);
    out_nxt.vertex_color = s2_r.color;
    out_nxt.corner       = s2_r.corner;
    out_nxt.last_vertex  = s2_r.corner == CORNER_LAST;
  end

  // Valid bits and corner counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (issue) begin
        corner_r <= corner_r + 2'd1;
      end
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- sv/sprite_quad_vertex_generator.sv -----
// Channel | Handshake             | Payload
// --------+-----------------------+------------------------------------------
// in      | in_valid / in_stall   | in_item (one sprite)
// out     | out_valid / out_stall | out_item (one vertex, four per sprite)
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (texture size)
//
// One vertex per cycle on out while out_stall is low; the result channel
// sets that rate. A sprite's first vertex reaches out after the edge that
// queues it, through two math stages and then the output register.
// Reset sets both texture sizes to 1. A cfg write runs in a bit-serial
// reciprocal divider; cfg_ready is low and in_stall high meanwhile.
// A held output stalls the vertex pipeline; the sprite queue keeps taking
// items until it is full.
module sprite_quad_vertex_generator
  import sqvg_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TSIZE_W-1:0]   cfg_data
);

  tex_scale_t scale;
  logic       head_valid;
  sq_entry_t  head;
  logic       pop;

  sqvg_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scale     (scale)
  );

  sqvg_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .hold       (scale.busy),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sqvg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .scale      (scale),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // Last flag marks exactly the fourth corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_vertex == (out_item.corner == CORNER_LAST)))
    else $error("last_vertex does not match corner");

  // No sprite enters while a reciprocal is being computed
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("item accepted during reciprocal update");

  // Texture coordinates never exceed 2.0
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.tex_s <= TEX_MAX && out_item.tex_t <= TEX_MAX))
    else $error("texture coordinate above 2.0");

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
